// ----- design/ecpa_pkg.sv -----
// Shared types, constants and modular helpers for the elliptic curve point adder.
// Used by ecpa_ctrl, ecpa_dpath and ec_point_add_prime_field; depends on nothing.
package ecpa_pkg;

  localparam int FW    = 16;
  localparam int CNT_W = $clog2(FW);
  localparam int CFG_W = 1;

  localparam logic [CFG_W-1:0] CFG_PRIME = 1'b0;
  localparam logic [CFG_W-1:0] CFG_A     = 1'b1;

  localparam logic [FW-1:0] PRIME_RST = FW'(7);
  localparam logic [FW-1:0] A_RST     = FW'(6);

  typedef struct packed {
    logic [FW-1:0] p_x;
    logic [FW-1:0] p_y;
    logic [FW-1:0] q_x;
    logic [FW-1:0] q_y;
  } ecpa_in_t;

  typedef enum logic [2:0] {
    CASE_P_ZERO   = 3'd0,
    CASE_Q_ZERO   = 3'd1,
    CASE_OPPOSITE = 3'd2,
    CASE_DOUBLE   = 3'd3,
    CASE_CHORD    = 3'd4
  } case_t;

  typedef struct packed {
    logic [FW-1:0] r_x;
    logic [FW-1:0] r_y;
    logic [2:0]    case_code;
  } ecpa_out_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_ADD, OP_SUB, OP_MUL, OP_RED, OP_EINIT, OP_EDIV, OP_EFIN, OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    SEL_PX, SEL_PY, SEL_QX, SEL_QY, SEL_NUM, SEL_DEN, SEL_SL, SEL_TMP, SEL_ZERO, SEL_A
  } sel_t;

  typedef struct packed {
    dp_op_t op;
    sel_t   dst;
    sel_t   src_a;
    sel_t   src_b;
    case_t  code;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic p_zero;
    logic q_zero;
    logic x_eq;
    logic y_eq;
    logic y_neg;
    logic r1_zero;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RED_PX, ST_RED_PY, ST_RED_QX, ST_RED_QY, ST_CLASSIFY,
    ST_D_SQ, ST_D_X2, ST_D_X3, ST_D_RA, ST_D_NUM, ST_D_DEN,
    ST_C_NUM, ST_C_DEN, ST_E_INIT, ST_E_LOOP, ST_E_FIN, ST_SLOPE,
    ST_X_SQ, ST_X_S1, ST_X_S2, ST_Y_D, ST_Y_M, ST_Y_A, ST_Y_N, ST_OUT
  } ctrl_state_t;

  function automatic logic [FW-1:0] mod_add(input logic [FW-1:0] a, input logic [FW-1:0] b,
                                            input logic [FW-1:0] m);
    logic [FW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[FW-1:0];
  endfunction

  function automatic logic [FW-1:0] mod_sub(input logic [FW-1:0] a, input logic [FW-1:0] b,
                                            input logic [FW-1:0] m);
    logic [FW:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + {1'b0, m} - {1'b0, b};
    return s[FW-1:0];
  endfunction

endpackage

// ----- design/ecpa_ctrl.sv -----
// Sequencer for the point adder: walks the reduction, slope, inverse and result steps.
// Depends on ecpa_pkg; drives ecpa_dpath through command and status structs.
module ecpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output ecpa_pkg::dp_cmd_t   cmd,
  input  ecpa_pkg::dp_status_t st
);
  import ecpa_pkg::*;

  ctrl_state_t state_r, state_nxt, tgt;
  logic        wait_r, wait_nxt;
  case_t       code_r, code_nxt;
  logic        ser;
  dp_cmd_t     c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r  <= 1'b0;
      code_r  <= CASE_P_ZERO;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    code_nxt  = code_r;
    tgt       = state_r;
    ser       = 1'b0;
    c         = '{op: OP_NONE, dst: SEL_ZERO, src_a: SEL_ZERO, src_b: SEL_ZERO, code: code_r};
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          c.op      = OP_LOAD;
          state_nxt = ST_RED_PX;
        end
      end
      ST_RED_PX: begin
        ser = 1'b1; c.op = OP_RED; c.dst = SEL_PX; c.src_a = SEL_PX; tgt = ST_RED_PY;
      end
      ST_RED_PY: begin
        ser = 1'b1; c.op = OP_RED; c.dst = SEL_PY; c.src_a = SEL_PY; tgt = ST_RED_QX;
      end
      ST_RED_QX: begin
        ser = 1'b1; c.op = OP_RED; c.dst = SEL_QX; c.src_a = SEL_QX; tgt = ST_RED_QY;
      end
      ST_RED_QY: begin
        ser = 1'b1; c.op = OP_RED; c.dst = SEL_QY; c.src_a = SEL_QY; tgt = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        if (st.p_zero) begin
          code_nxt = CASE_P_ZERO; state_nxt = ST_OUT;
        end else if (st.q_zero) begin
          code_nxt = CASE_Q_ZERO; state_nxt = ST_OUT;
        end else if (st.x_eq && st.y_neg) begin
          code_nxt = CASE_OPPOSITE; state_nxt = ST_OUT;
        end else if (st.x_eq && st.y_eq) begin
          code_nxt = CASE_DOUBLE; state_nxt = ST_D_SQ;
        end else begin
          code_nxt = CASE_CHORD; state_nxt = ST_C_NUM;
        end
      end
      // Tangent numerator 3x^2 + a and denominator 2y.
      ST_D_SQ: begin
        ser = 1'b1; c.op = OP_MUL; c.dst = SEL_TMP; c.src_a = SEL_PX; c.src_b = SEL_PX;
        tgt = ST_D_X2;
      end
      ST_D_X2: begin
        c.op = OP_ADD; c.dst = SEL_NUM; c.src_a = SEL_TMP; c.src_b = SEL_TMP;
        state_nxt = ST_D_X3;
      end
      ST_D_X3: begin
        c.op = OP_ADD; c.dst = SEL_NUM; c.src_a = SEL_NUM; c.src_b = SEL_TMP;
        state_nxt = ST_D_RA;
      end
      ST_D_RA: begin
        ser = 1'b1; c.op = OP_RED; c.dst = SEL_TMP; c.src_a = SEL_A; tgt = ST_D_NUM;
      end
      ST_D_NUM: begin
        c.op = OP_ADD; c.dst = SEL_NUM; c.src_a = SEL_NUM; c.src_b = SEL_TMP;
        state_nxt = ST_D_DEN;
      end
      ST_D_DEN: begin
        c.op = OP_ADD; c.dst = SEL_DEN; c.src_a = SEL_PY; c.src_b = SEL_PY;
        state_nxt = ST_E_INIT;
      end
      ST_C_NUM: begin
        c.op = OP_SUB; c.dst = SEL_NUM; c.src_a = SEL_PY; c.src_b = SEL_QY;
        state_nxt = ST_C_DEN;
      end
      ST_C_DEN: begin
        c.op = OP_SUB; c.dst = SEL_DEN; c.src_a = SEL_PX; c.src_b = SEL_QX;
        state_nxt = ST_E_INIT;
      end
      ST_E_INIT: begin
        c.op = OP_EINIT; c.src_a = SEL_DEN; state_nxt = ST_E_LOOP;
      end
      ST_E_LOOP: begin
        // One Euclid division step per pass until the remainder reaches zero.
        if (!wait_r && st.r1_zero) begin
          state_nxt = ST_E_FIN;
        end else begin
          ser = 1'b1; c.op = OP_EDIV; tgt = ST_E_LOOP;
        end
      end
      ST_E_FIN: begin
        c.op = OP_EFIN; c.dst = SEL_DEN; state_nxt = ST_SLOPE;
      end
      ST_SLOPE: begin
        ser = 1'b1; c.op = OP_MUL; c.dst = SEL_SL; c.src_a = SEL_NUM; c.src_b = SEL_DEN;
        tgt = ST_X_SQ;
      end
      ST_X_SQ: begin
        ser = 1'b1; c.op = OP_MUL; c.dst = SEL_TMP; c.src_a = SEL_SL; c.src_b = SEL_SL;
        tgt = ST_X_S1;
      end
      ST_X_S1: begin
        c.op = OP_SUB; c.dst = SEL_TMP; c.src_a = SEL_TMP; c.src_b = SEL_PX;
        state_nxt = ST_X_S2;
      end
      ST_X_S2: begin
        c.op = OP_SUB; c.dst = SEL_NUM; c.src_a = SEL_TMP; c.src_b = SEL_QX;
        state_nxt = ST_Y_D;
      end
      ST_Y_D: begin
        c.op = OP_SUB; c.dst = SEL_TMP; c.src_a = SEL_NUM; c.src_b = SEL_PX;
        state_nxt = ST_Y_M;
      end
      ST_Y_M: begin
        ser = 1'b1; c.op = OP_MUL; c.dst = SEL_TMP; c.src_a = SEL_SL; c.src_b = SEL_TMP;
        tgt = ST_Y_A;
      end
      ST_Y_A: begin
        c.op = OP_ADD; c.dst = SEL_TMP; c.src_a = SEL_PY; c.src_b = SEL_TMP;
        state_nxt = ST_Y_N;
      end
      ST_Y_N: begin
        c.op = OP_SUB; c.dst = SEL_TMP; c.src_a = SEL_ZERO; c.src_b = SEL_TMP;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        c.op = OP_OUT;
        case (code_r)
          CASE_P_ZERO:   begin c.src_a = SEL_QX;   c.src_b = SEL_QY;   end
          CASE_Q_ZERO:   begin c.src_a = SEL_PX;   c.src_b = SEL_PY;   end
          CASE_OPPOSITE: begin c.src_a = SEL_ZERO; c.src_b = SEL_ZERO; end
          default:       begin c.src_a = SEL_NUM;  c.src_b = SEL_TMP;  end
        endcase
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    cmd = c;
    if (ser) begin
      if (!wait_r) begin
        wait_nxt = 1'b1;
      end else begin
        cmd.op = OP_NONE;
        if (st.done) begin
          wait_nxt  = 1'b0;
          state_nxt = tgt;
        end
      end
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- design/ecpa_dpath.sv -----
// Datapath of the point adder: coordinate registers, combinational add and subtract,
// and a bit-serial unit for reduction, modular product and Euclid steps. Uses ecpa_pkg.
module ecpa_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ecpa_pkg::ecpa_in_t        in_data,
  input  logic                      cfg_we,
  input  logic [ecpa_pkg::CFG_W-1:0] cfg_addr,
  input  logic [ecpa_pkg::FW-1:0]   cfg_wdata,
  input  ecpa_pkg::dp_cmd_t         cmd,
  output ecpa_pkg::dp_status_t      st,
  output logic                      out_valid,
  output ecpa_pkg::ecpa_out_t       out_data
);
  import ecpa_pkg::*;

  logic [FW-1:0] prime_r, a_r, m_r;
  logic [FW-1:0] px_r, py_r, qx_r, qy_r, num_r, den_r, sl_r, tmp_r;
  logic [FW-1:0] r0_r, r1_r, s0_r, s1_r;
  logic          ser_busy_r, out_valid_r;
  logic [CNT_W-1:0] ser_cnt_r;
  dp_op_t        ser_op_r;
  sel_t          ser_dst_r;
  logic [FW-1:0] sh_r, rem_r, acc_r, div_r, add_r;
  ecpa_out_t     out_r;

  logic [FW-1:0] opa, opb, m_eff;
  logic          ser_go, last, b, ge, addbit;
  logic [FW:0]   rt, dbl;
  logic [FW-1:0] rem_n, acc2, acc_n;
  logic          wr_en;
  sel_t          wr_sel;
  logic [FW-1:0] wr_val;

  always_comb begin
    case (cmd.src_a)
      SEL_PX:  opa = px_r;
      SEL_PY:  opa = py_r;
      SEL_QX:  opa = qx_r;
      SEL_QY:  opa = qy_r;
      SEL_NUM: opa = num_r;
      SEL_DEN: opa = den_r;
      SEL_SL:  opa = sl_r;
      SEL_TMP: opa = tmp_r;
      SEL_A:   opa = a_r;
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (cmd.src_b)
      SEL_PX:  opb = px_r;
      SEL_PY:  opb = py_r;
      SEL_QX:  opb = qx_r;
      SEL_QY:  opb = qy_r;
      SEL_NUM: opb = num_r;
      SEL_DEN: opb = den_r;
      SEL_SL:  opb = sl_r;
      SEL_TMP: opb = tmp_r;
      SEL_A:   opb = a_r;
      default: opb = '0;
    endcase
  end

  // A modulus of zero or one behaves as one, which reduces every value to zero.
  assign m_eff  = (prime_r < FW'(2)) ? FW'(1) : prime_r;
  assign ser_go = (cmd.op == OP_MUL) || (cmd.op == OP_RED) || (cmd.op == OP_EDIV);

  // Serial step: restoring division on rem, and a Horner-style modular sum on acc
  // fed either by the multiplier bit or by the quotient bit just produced.
  always_comb begin
    b      = sh_r[FW-1];
    rt     = {rem_r, b};
    ge     = (rt >= {1'b0, div_r});
    rem_n  = ge ? FW'(rt - {1'b0, div_r}) : rt[FW-1:0];
    addbit = (ser_op_r == OP_MUL) ? b : ge;
    dbl    = {acc_r, 1'b0};
    acc2   = (dbl >= {1'b0, m_r}) ? FW'(dbl - {1'b0, m_r}) : dbl[FW-1:0];
    acc_n  = addbit ? mod_add(acc2, add_r, m_r) : acc2;
    last   = ser_busy_r && (ser_cnt_r == CNT_W'(FW - 1));
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_sel = cmd.dst;
    wr_val = '0;
    if (last && (ser_op_r != OP_EDIV)) begin
      wr_en  = 1'b1;
      wr_sel = ser_dst_r;
      wr_val = (ser_op_r == OP_MUL) ? acc_n : rem_n;
    end else begin
      case (cmd.op)
        OP_ADD:  begin wr_en = 1'b1; wr_val = mod_add(opa, opb, m_r); end
        OP_SUB:  begin wr_en = 1'b1; wr_val = mod_sub(opa, opb, m_r); end
        OP_EFIN: begin wr_en = 1'b1; wr_val = (r0_r == FW'(1)) ? s0_r : '0; end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r     <= PRIME_RST;
      a_r         <= A_RST;
      ser_busy_r  <= 1'b0;
      ser_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_PRIME: prime_r <= cfg_wdata;
          CFG_A:     a_r     <= cfg_wdata;
          default:   ;
        endcase
      end
      out_valid_r <= (cmd.op == OP_OUT);
      if (ser_go) begin
        ser_busy_r <= 1'b1;
        ser_cnt_r  <= '0;
      end else if (ser_busy_r) begin
        ser_cnt_r <= ser_cnt_r + CNT_W'(1);
        if (last) ser_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      px_r <= in_data.p_x;
      py_r <= in_data.p_y;
      qx_r <= in_data.q_x;
      qy_r <= in_data.q_y;
      m_r  <= m_eff;
    end
    if (wr_en) begin
      case (wr_sel)
        SEL_PX:  px_r  <= wr_val;
        SEL_PY:  py_r  <= wr_val;
        SEL_QX:  qx_r  <= wr_val;
        SEL_QY:  qy_r  <= wr_val;
        SEL_NUM: num_r <= wr_val;
        SEL_DEN: den_r <= wr_val;
        SEL_SL:  sl_r  <= wr_val;
        SEL_TMP: tmp_r <= wr_val;
        default: ;
      endcase
    end
    if (cmd.op == OP_EINIT) begin
      r0_r <= opa;
      r1_r <= m_r;
      s0_r <= FW'(1);
      s1_r <= '0;
    end else if (last && (ser_op_r == OP_EDIV)) begin
      r0_r <= r1_r;
      r1_r <= rem_n;
      s0_r <= s1_r;
      s1_r <= mod_sub(s0_r, acc_n, m_r);
    end
    if (ser_go) begin
      ser_op_r  <= cmd.op;
      ser_dst_r <= cmd.dst;
      rem_r     <= '0;
      acc_r     <= '0;
      unique case (cmd.op)
        OP_MUL: begin
          sh_r <= opb; add_r <= opa; div_r <= m_r;
        end
        OP_RED: begin
          sh_r <= opa; add_r <= '0; div_r <= m_r;
        end
        default: begin
          sh_r <= r0_r; add_r <= s1_r; div_r <= r1_r;
        end
      endcase
    end else if (ser_busy_r) begin
      sh_r  <= {sh_r[FW-2:0], 1'b0};
      rem_r <= rem_n;
      acc_r <= acc_n;
    end
    if (cmd.op == OP_OUT) begin
      out_r.r_x       <= opa;
      out_r.r_y       <= opb;
      out_r.case_code <= cmd.code;
    end
  end

  assign st.done    = last;
  assign st.p_zero  = (px_r == '0) && (py_r == '0);
  assign st.q_zero  = (qx_r == '0) && (qy_r == '0);
  assign st.x_eq    = (px_r == qx_r);
  assign st.y_eq    = (py_r == qy_r);
  assign st.y_neg   = (py_r == ((qy_r == '0) ? '0 : FW'(m_r - qy_r)));
  assign st.r1_zero = (r1_r == '0);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n) ser_go |-> !ser_busy_r)
    else $error("serial unit started while still running");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !ser_busy_r)
    else $error("result word issued while the serial unit runs");
  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    (last && !ser_go) |=> !ser_busy_r)
    else $error("serial unit did not stop after its last step");
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_busy_r && $past(ser_busy_r)) |-> (acc_r < m_r))
    else $error("serial accumulator left the field");
`endif

endmodule

// ----- design/ec_point_add_prime_field.sv -----
// Top level of the affine point adder over GF(p): controller plus datapath.
// Depends on ecpa_pkg, ecpa_ctrl and ecpa_dpath.
//
// Usage: present both points on in_data and raise start while busy is low; the
// word is taken at that edge and busy rises on the next cycle. The sum appears
// on out_data for exactly one cycle with out_valid high; the receiver cannot
// stall, so it must take the word in that cycle. busy falls as out_valid rises,
// and a new start is taken from then on, so the time per item equals its latency.
// One item at a time: each serial operation (reduction, modular product or one
// Euclid division step) runs 16 steps of the shared bit-serial unit, and the add
// and subtract steps are computed combinationally. When a point is zero or the
// points are opposite, only the four input reductions, classification and output
// run. A doubling or chord adds the products and the inverse, whose Euclid loop
// runs one division step per pass until the remainder reaches zero.
// Configuration: cfg_we writes field_prime (index 0) or curve_a (index 1); the user
// must write them only while busy is low, which the block does not enforce.
// Reset sets field_prime to 7 and curve_a to 6 and idles the block.
module ec_point_add_prime_field (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  ecpa_pkg::ecpa_in_t         in_data,
  output logic                       out_valid,
  output ecpa_pkg::ecpa_out_t        out_data,
  input  logic                       cfg_we,
  input  logic [ecpa_pkg::CFG_W-1:0] cfg_addr,
  input  logic [ecpa_pkg::FW-1:0]    cfg_wdata
);
  import ecpa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  ecpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .st    (st)
  );

  ecpa_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
